/* hw/rtl/fbpa_pkg.sv */
// Package for the fixed block pool allocator: sizes, operation and status codes,
// and the command and status structs between the controller and the datapath.
// It has no dependencies.
`default_nettype none

package fbpa_pkg;

   localparam int POOL_BLOCKS = 512;
   localparam int IDX_W       = $clog2(POOL_BLOCKS);
   localparam int LINK_W      = IDX_W + 1;
   localparam int WIDE_W      = (LINK_W > 10) ? LINK_W : 10;

   localparam int OP_W     = 2;
   localparam int BIDX_W   = 9;
   localparam int STATUS_W = 2;
   localparam int OFS_W    = 21;
   localparam int BYTES_W  = 13;
   localparam int COUNT_W  = 10;
   localparam int CSR_IDX_W = 1;

   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK  = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_OOM = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 1'b1;

   localparam logic [BYTES_W-1:0] BYTES_RESET = 13'd64;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 10'd512;

   typedef struct packed {
      logic                capture;
      logic                rd_head;
      logic                rd_cur;
      logic                load_cur;
      logic                pop_head;
      logic                bump;
      logic                clear;
      logic                wr_b;
      logic                link_prev;
      logic                set_res;
      logic [STATUS_W-1:0] res_status;
      logic                res_given;
      logic                res_from_frontier;
      logic                emit;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            list_empty;
      logic            pool_full;
      logic            bad_range;
      logic            walk_go;
      logic            cur_is_b;
   } stat_type;

endpackage

`default_nettype wire

/* hw/rtl/fbpa_datapath.sv */
// Datapath of the fixed block pool allocator: list head, frontier, link memory,
// list walk registers, configuration registers and the result stage.
// It depends on fbpa_pkg.
`default_nettype none

module fbpa_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire fbpa_pkg::cmd_type                   cmd,
   output      fbpa_pkg::stat_type                  stat,
   input  wire logic [fbpa_pkg::OP_W-1:0]           req_operation,
   input  wire logic [fbpa_pkg::BIDX_W-1:0]         req_block_index,
   input  wire logic                                csr_valid,
   input  wire logic                                csr_ready,
   input  wire logic [fbpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [fbpa_pkg::BYTES_W-1:0]        csr_data,
   output      logic                                rsp_valid,
   output      logic [fbpa_pkg::STATUS_W-1:0]       rsp_status,
   output      logic [fbpa_pkg::BIDX_W-1:0]         rsp_given_index,
   output      logic [fbpa_pkg::OFS_W-1:0]          rsp_byte_offset
);

   logic [fbpa_pkg::LINK_W-1:0]   mem [fbpa_pkg::POOL_BLOCKS];
   logic [fbpa_pkg::LINK_W-1:0]   rd_data_ff;
   logic [fbpa_pkg::IDX_W-1:0]    rd_addr;
   logic                          wr_en;
   logic [fbpa_pkg::IDX_W-1:0]    wr_addr;
   logic [fbpa_pkg::LINK_W-1:0]   wr_data;

   logic [fbpa_pkg::LINK_W-1:0]   head_ff, head_in;
   logic [fbpa_pkg::LINK_W-1:0]   frontier_ff, frontier_in;
   logic [fbpa_pkg::LINK_W-1:0]   frontier_inc;
   logic [fbpa_pkg::LINK_W-1:0]   cur_ff;
   logic [fbpa_pkg::IDX_W-1:0]    prev_ff;
   logic                          has_prev_ff;
   logic [fbpa_pkg::OP_W-1:0]     op_ff;
   logic [fbpa_pkg::WIDE_W-1:0]   b_ff;
   logic [fbpa_pkg::BYTES_W-1:0]  bytes_ff;
   logic [fbpa_pkg::COUNT_W-1:0]  count_ff;

   logic [fbpa_pkg::STATUS_W-1:0] res_status_ff;
   logic                          res_given_ff;
   logic [fbpa_pkg::IDX_W-1:0]    res_idx_ff;

   logic                          rsp_valid_ff;
   logic [fbpa_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [fbpa_pkg::BIDX_W-1:0]   rsp_given_ff;
   logic [fbpa_pkg::OFS_W-1:0]    rsp_offset_ff;

   logic [fbpa_pkg::WIDE_W-1:0]   head_w, frontier_w, cur_w, count_w, pool_w, res_idx_w;
   logic [fbpa_pkg::BIDX_W-1:0]   given9;
   logic [fbpa_pkg::OFS_W:0]      product;

   assign head_w     = fbpa_pkg::WIDE_W'(head_ff);
   assign frontier_w = fbpa_pkg::WIDE_W'(frontier_ff);
   assign cur_w      = fbpa_pkg::WIDE_W'(cur_ff);
   assign count_w    = fbpa_pkg::WIDE_W'(count_ff);
   assign pool_w     = fbpa_pkg::WIDE_W'(fbpa_pkg::POOL_BLOCKS);
   assign res_idx_w  = fbpa_pkg::WIDE_W'(res_idx_ff);
   assign given9     = res_idx_w[fbpa_pkg::BIDX_W-1:0];
   assign product    = (fbpa_pkg::OFS_W+1)'(given9) * (fbpa_pkg::OFS_W+1)'(bytes_ff);
   assign frontier_inc = frontier_ff + fbpa_pkg::LINK_W'(1);

   always_comb begin
      stat.op         = op_ff;
      stat.list_empty = (head_ff == frontier_ff);
      stat.pool_full  = (frontier_w >= count_w) || (frontier_w >= pool_w);
      stat.bad_range  = (b_ff >= frontier_w) || (b_ff >= pool_w);
      stat.walk_go    = (cur_w != frontier_w) && (cur_w < b_ff);
      stat.cur_is_b   = (cur_w == b_ff);
   end

   always_comb begin
      head_in     = head_ff;
      frontier_in = frontier_ff;
      if (cmd.clear) begin
         head_in     = '0;
         frontier_in = '0;
      end else if (cmd.bump) begin
         head_in     = frontier_inc;
         frontier_in = frontier_inc;
      end else if (cmd.pop_head) begin
         head_in = rd_data_ff;
      end else if (cmd.link_prev && !has_prev_ff) begin
         head_in = b_ff[fbpa_pkg::LINK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         frontier_ff <= '0;
         bytes_ff    <= fbpa_pkg::BYTES_RESET;
         count_ff    <= fbpa_pkg::COUNT_RESET;
      end else begin
         head_ff     <= head_in;
         frontier_ff <= frontier_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               fbpa_pkg::CSR_BLOCK_BYTES: bytes_ff <= csr_data;
               fbpa_pkg::CSR_BLOCK_COUNT: count_ff <= csr_data[fbpa_pkg::COUNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_operation;
         b_ff        <= fbpa_pkg::WIDE_W'(req_block_index);
         cur_ff      <= head_ff;
         has_prev_ff <= 1'b0;
      end else begin
         if (cmd.load_cur) begin
            cur_ff <= rd_data_ff;
         end
         if (cmd.rd_cur) begin
            prev_ff     <= cur_ff[fbpa_pkg::IDX_W-1:0];
            has_prev_ff <= 1'b1;
         end
      end
      if (cmd.set_res) begin
         res_status_ff <= cmd.res_status;
         res_given_ff  <= cmd.res_given;
         res_idx_ff    <= cmd.res_from_frontier ? frontier_ff[fbpa_pkg::IDX_W-1:0]
                                                : head_ff[fbpa_pkg::IDX_W-1:0];
      end
   end

   assign rd_addr = cmd.rd_head ? head_ff[fbpa_pkg::IDX_W-1:0] : cur_ff[fbpa_pkg::IDX_W-1:0];
   assign wr_en   = cmd.wr_b || (cmd.link_prev && has_prev_ff);
   assign wr_addr = cmd.wr_b ? b_ff[fbpa_pkg::IDX_W-1:0] : prev_ff;
   assign wr_data = cmd.wr_b ? cur_ff : b_ff[fbpa_pkg::LINK_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_head || cmd.rd_cur) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         rsp_status_ff <= res_status_ff;
         rsp_given_ff  <= res_given_ff ? given9 : '0;
         rsp_offset_ff <= res_given_ff ? product[fbpa_pkg::OFS_W-1:0] : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_given_index = rsp_given_ff;
   assign rsp_byte_offset = rsp_offset_ff;

   wr_ports_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_b && cmd.link_prev))
      else $error("link memory written for the new block and its predecessor at once");

   pop_only_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_head |-> (head_ff != frontier_ff))
      else $error("allocate popped an empty free list");

   emit_after_result: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("result strobe missing after emit");

endmodule

`default_nettype wire

/* hw/rtl/fbpa_ctrl.sv */
// Controller of the fixed block pool allocator: sequences allocate, the sorted
// free list walk and insertion, clear, and result delivery.
// It depends on fbpa_pkg.
`default_nettype none

module fbpa_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire fbpa_pkg::stat_type stat,
   output      fbpa_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_ALLOC_WAIT,
      S_WALK,
      S_WALK_WAIT,
      S_LINK,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.set_res    = 1'b1;
            cmd.res_status = fbpa_pkg::STAT_OK;
            state_in       = S_RESP;
            case (stat.op)
               fbpa_pkg::OP_ALLOC: begin
                  if (!stat.list_empty) begin
                     cmd.rd_head   = 1'b1;
                     cmd.res_given = 1'b1;
                     state_in      = S_ALLOC_WAIT;
                  end else if (stat.pool_full) begin
                     cmd.res_status = fbpa_pkg::STAT_OOM;
                  end else begin
                     cmd.bump              = 1'b1;
                     cmd.res_given         = 1'b1;
                     cmd.res_from_frontier = 1'b1;
                  end
               end
               fbpa_pkg::OP_FREE: begin
                  if (stat.bad_range) begin
                     cmd.res_status = fbpa_pkg::STAT_BAD;
                  end else begin
                     cmd.set_res = 1'b0;
                     state_in    = S_WALK;
                  end
               end
               fbpa_pkg::OP_CLEAR: begin
                  cmd.clear = 1'b1;
               end
               default: ;
            endcase
         end
         S_ALLOC_WAIT: begin
            cmd.pop_head = 1'b1;
            state_in     = S_RESP;
         end
         S_WALK: begin
            if (stat.walk_go) begin
               cmd.rd_cur = 1'b1;
               state_in   = S_WALK_WAIT;
            end else if (stat.cur_is_b) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = fbpa_pkg::STAT_BAD;
               state_in       = S_RESP;
            end else begin
               cmd.wr_b = 1'b1;
               state_in = S_LINK;
            end
         end
         S_WALK_WAIT: begin
            cmd.load_cur = 1'b1;
            state_in     = S_WALK;
         end
         S_LINK: begin
            cmd.link_prev  = 1'b1;
            cmd.set_res    = 1'b1;
            cmd.res_status = fbpa_pkg::STAT_OK;
            state_in       = S_RESP;
         end
         S_RESP: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;

   accept_dispatches: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_DISPATCH))
      else $error("accepted request did not reach dispatch");

   busy_matches_state: assert property (@(posedge clock) disable iff (reset)
      busy == (state_ff != S_IDLE))
      else $error("busy disagrees with controller state");

   walk_wait_follows_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK_WAIT) |-> ($past(state_ff) == S_WALK))
      else $error("walk wait entered from the wrong state");

endmodule

`default_nettype wire

/* hw/rtl/fixed_block_pool_allocator.sv */
// Top level of the fixed block pool allocator: controller plus datapath.
// It depends on fbpa_pkg, fbpa_ctrl and fbpa_datapath.
//
// A request (req_operation, req_block_index) is taken when start is high and
// busy is low. Operations are allocate, free and clear. Each request gives one
// result on rsp_status, rsp_given_index and rsp_byte_offset, marked by rsp_valid
// for exactly one cycle; the receiver cannot stall it.
// Clear, unused codes, a frontier or out-of-memory allocate and an out-of-range
// free go from dispatch straight to the result; an allocate from the free list
// first reads the head's link. A free walks the sorted list with one link read
// per free list entry below the freed index; an inserted block then writes its
// own link, then its predecessor's link or the head; an already free one gets BAD.
// One request is in flight at a time; busy drops as the result is delivered, so
// the next request can be taken at the edge that ends the result strobe.
// Configuration writes use csr_valid, csr_ready, csr_index and csr_data; they
// are always accepted and are meant for idle periods only.
// Reset empties the pool and loads block_bytes 64 and block_count 512. The link
// memory needs no clearing pass, so a request can be taken right after reset.
`default_nettype none

module fixed_block_pool_allocator (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output      logic                           busy,
   input  wire logic [fbpa_pkg::OP_W-1:0]      req_operation,
   input  wire logic [fbpa_pkg::BIDX_W-1:0]    req_block_index,
   output      logic                           rsp_valid,
   output      logic [fbpa_pkg::STATUS_W-1:0]  rsp_status,
   output      logic [fbpa_pkg::BIDX_W-1:0]    rsp_given_index,
   output      logic [fbpa_pkg::OFS_W-1:0]     rsp_byte_offset,
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [fbpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [fbpa_pkg::BYTES_W-1:0]   csr_data
);

   fbpa_pkg::cmd_type  cmd;
   fbpa_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   fbpa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   fbpa_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_operation   (req_operation),
      .req_block_index (req_block_index),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_given_index (rsp_given_index),
      .rsp_byte_offset (rsp_byte_offset)
   );

endmodule

`default_nettype wire
